// ===== sv/rpn_stack_calculator_unit_assert.svh =====
// Assertion macros for the stack calculator
`ifndef RPN_STACK_CALCULATOR_UNIT_ASSERT_SVH
`define RPN_STACK_CALCULATOR_UNIT_ASSERT_SVH

`define RPN_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rpn_pkg.sv =====
`default_nettype none
package rpn_pkg;
    localparam int unsigned STACK_DEPTH_DEF = 128;
    localparam int unsigned OP_W = 4;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_CLEAR = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH  = 4'd1;
    localparam logic [OP_W-1:0] OP_OUTN  = 4'd2;
    localparam logic [OP_W-1:0] OP_OUTC  = 4'd3;
    localparam logic [OP_W-1:0] OP_ADD   = 4'd4;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd6;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd7;
    localparam logic [OP_W-1:0] OP_MOD   = 4'd8;
    localparam logic [OP_W-1:0] OP_QUIT  = 4'd9;

    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NUMBER  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CHAR    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FAULT   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd5;
    localparam logic [STATUS_W-1:0] ST_HALTED  = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] data;
    } out_beat_t;

    // classified command handed from front to back
    typedef enum logic [3:0] {
        K_CLEAR = 4'd0,
        K_PUSH  = 4'd1,
        K_POP   = 4'd2,
        K_BIN   = 4'd3,
        K_QUIT  = 4'd4,
        K_UNK   = 4'd5
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [OP_W-1:0]          op;
        logic [DATA_W-1:0]        value;
    } cmd_t;
endpackage
`default_nettype wire

// ===== sv/rpn_front.sv =====
`default_nettype none
module rpn_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rpn_pkg::in_beat_t in_beat,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output rpn_pkg::cmd_t         q_cmd,
    output logic                  q_valid,
    input  wire logic             q_pop
);
    // two-entry queue
    rpn_pkg::cmd_t q_mem_reg [2];
    logic          rd_ptr_reg, rd_ptr_next;
    logic          wr_ptr_reg, wr_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    rpn_pkg::cmd_t cls;
    logic          push;

    always_comb
    begin
        cls.op    = in_beat.op;
        cls.value = in_beat.value;
        unique case (in_beat.op)
            rpn_pkg::OP_CLEAR: cls.kind = rpn_pkg::K_CLEAR;
            rpn_pkg::OP_PUSH:  cls.kind = rpn_pkg::K_PUSH;
            rpn_pkg::OP_OUTN,
            rpn_pkg::OP_OUTC:  cls.kind = rpn_pkg::K_POP;
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL,
            rpn_pkg::OP_DIV, rpn_pkg::OP_MOD: cls.kind = rpn_pkg::K_BIN;
            rpn_pkg::OP_QUIT:  cls.kind = rpn_pkg::K_QUIT;
            default:           cls.kind = rpn_pkg::K_UNK;
        endcase
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

    `include "rpn_stack_calculator_unit_assert.svh"
    `RPN_ASSERT_IMPL(a_no_pop_empty, q_pop, cnt_reg != 2'd0, "pop from empty queue")
    `RPN_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_reg <= 2'd2, "queue count out of range")
    `RPN_ASSERT_NEXT(a_full_after, push && !q_pop && cnt_reg == 2'd1, in_stall, "queue not full")
endmodule
`default_nettype wire

// ===== sv/rpn_divider.sv =====
`default_nettype none
module rpn_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic             done,
    output logic [31:0]      quot,
    output logic [31:0]      rem
);
    // radix-2 restoring divide on magnitudes, one bit a cycle
    logic [31:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        nq_reg, nq_next, nr_reg, nr_next;
    logic [32:0] trial;

    assign trial = {r_reg[31:0], q_reg[31]} - {1'b0, d_reg};

    always_comb
    begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; nq_next = nq_reg; nr_next = nr_reg;
        done = 1'b0;
        if (start)
        begin
            q_next    = a[31] ? 32'd0 - a : a;
            d_next    = b[31] ? 32'd0 - b : b;
            r_next    = 33'd0;
            nq_next   = a[31] ^ b[31];
            nr_next   = a[31];
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd32)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
            else
            begin
                if (!trial[32])
                begin
                    r_next = trial;
                    q_next = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    r_next = {r_reg[31:0], q_reg[31]};
                    q_next = {q_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
            end
        end
    end

    assign quot = nq_reg ? 32'd0 - q_reg : q_reg;
    assign rem  = nr_reg ? 32'd0 - r_reg[31:0] : r_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
        nq_reg <= nq_next; nr_reg <= nr_next;
    end
endmodule
`default_nettype wire

// ===== sv/rpn_back.sv =====
`default_nettype none
module rpn_back #(
    parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rpn_pkg::cmd_t  q_cmd,
    input  wire logic           q_valid,
    output logic                q_pop,
    output rpn_pkg::out_beat_t  out_beat,
    output logic                out_valid,
    input  wire logic           out_stall
);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RD1   = 6'b000010,
        S_RD2   = 6'b000100,
        S_EXEC  = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic        rd_en;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0] wr_data;

    state_t      state_reg, state_next;
    logic [7:0]  sp_reg, sp_next;
    logic        halt_reg, halt_next;
    rpn_pkg::cmd_t cmd_reg, cmd_next;
    logic [31:0] opb_reg, opb_next;
    logic [31:0] opa_reg, opa_next;
    logic [31:0] prod_reg;
    logic        pv_reg, pv_next;
    logic        ov_reg, ov_next;
    rpn_pkg::out_beat_t ob_reg, ob_next;
    logic        div_start, div_done;
    logic [31:0] div_q, div_r;

    rpn_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .a(opa_reg), .b(opb_reg),
        .done(div_done), .quot(div_q), .rem(div_r)
    );

    assign out_valid = ov_reg;
    assign out_beat  = ob_reg;

    always_comb
    begin
        state_next = state_reg; sp_next = sp_reg; halt_next = halt_reg;
        cmd_next = cmd_reg; opa_next = opa_reg; opb_next = opb_reg;
        pv_next = 1'b0; ob_next = ob_reg; ov_next = ov_reg;
        q_pop = 1'b0; rd_en = 1'b0; rd_addr = '0;
        wr_en = 1'b0; wr_addr = '0; wr_data = cmd_reg.value;
        div_start = 1'b0;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    ob_next.data   = '0;
                    ob_next.status = rpn_pkg::ST_DONE;
                    state_next = S_OUT;
                    if (halt_reg)
                    begin
                        ob_next.status = rpn_pkg::ST_HALTED;
                    end
                    else
                    begin
                        unique case (q_cmd.kind)
                            rpn_pkg::K_CLEAR: sp_next = 8'd0;
                            rpn_pkg::K_PUSH:
                            begin
                                if (32'(sp_reg) >= STACK_DEPTH)
                                begin
                                    halt_next = 1'b1;
                                    ob_next.status = rpn_pkg::ST_FAULT;
                                end
                                else
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = sp_reg[AW-1:0];
                                    wr_data = q_cmd.value;
                                    sp_next = sp_reg + 8'd1;
                                end
                            end
                            rpn_pkg::K_POP:
                            begin
                                if (sp_reg == 8'd0)
                                begin
                                    halt_next = 1'b1;
                                    ob_next.status = rpn_pkg::ST_FAULT;
                                end
                                else
                                begin
                                    rd_en   = 1'b1;
                                    rd_addr = AW'(sp_reg - 8'd1);
                                    sp_next = sp_reg - 8'd1;
                                    state_next = S_RD1;
                                end
                            end
                            rpn_pkg::K_BIN:
                            begin
                                if (sp_reg < 8'd2)
                                begin
                                    halt_next = 1'b1;
                                    ob_next.status = rpn_pkg::ST_FAULT;
                                end
                                else
                                begin
                                    rd_en   = 1'b1;
                                    rd_addr = AW'(sp_reg - 8'd1);
                                    state_next = S_RD1;
                                end
                            end
                            rpn_pkg::K_QUIT:
                            begin
                                halt_next = 1'b1;
                                ob_next.status = rpn_pkg::ST_HALTED;
                            end
                            default: ob_next.status = rpn_pkg::ST_UNKNOWN;
                        endcase
                    end
                    if (state_next == S_OUT)
                    begin
                        ov_next = 1'b1;
                        state_next = S_IDLE;
                        // hold until the output register is free
                        if (ov_reg && out_stall)
                        begin
                            q_pop = 1'b0; sp_next = sp_reg; halt_next = halt_reg;
                            wr_en = 1'b0; ov_next = ov_reg; ob_next = ob_reg;
                        end
                    end
                    else if (ov_reg && out_stall)
                    begin
                        q_pop = 1'b0; sp_next = sp_reg; rd_en = 1'b0;
                        state_next = S_IDLE; ob_next = ob_reg;
                    end
                end
            end
            S_RD1:
            begin
                if (cmd_reg.kind == rpn_pkg::K_POP)
                begin
                    ob_next.data = (cmd_reg.op == rpn_pkg::OP_OUTC) ?
                        {24'd0, rd_data_reg[7:0]} : rd_data_reg;
                    ob_next.status = (cmd_reg.op == rpn_pkg::OP_OUTC) ?
                        rpn_pkg::ST_CHAR : rpn_pkg::ST_NUMBER;
                    state_next = S_OUT;
                end
                else
                begin
                    opb_next = rd_data_reg;
                    rd_en    = 1'b1;
                    rd_addr  = AW'(sp_reg - 8'd2);
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                opa_next = rd_data_reg;
                pv_next  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if ((cmd_reg.op == rpn_pkg::OP_DIV || cmd_reg.op == rpn_pkg::OP_MOD) &&
                    opb_reg == 32'd0)
                begin
                    ob_next.status = rpn_pkg::ST_DIVZERO;
                    state_next = S_OUT;
                end
                else if (cmd_reg.op == rpn_pkg::OP_DIV || cmd_reg.op == rpn_pkg::OP_MOD)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else if (cmd_reg.op == rpn_pkg::OP_MUL && pv_reg)
                begin
                    // wait for the product register to be loaded
                    state_next = S_EXEC;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(sp_reg - 8'd2);
                    unique case (cmd_reg.op)
                        rpn_pkg::OP_ADD: wr_data = opa_reg + opb_reg;
                        rpn_pkg::OP_SUB: wr_data = opa_reg - opb_reg;
                        default:         wr_data = prod_reg;
                    endcase
                    sp_next = sp_reg - 8'd1;
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(sp_reg - 8'd2);
                    wr_data = (cmd_reg.op == rpn_pkg::OP_DIV) ? div_q : div_r;
                    sp_next = sp_reg - 8'd1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= 8'd0;
            halt_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            halt_reg  <= halt_next;
            ov_reg    <= ov_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        ob_reg  <= ob_next;
        if (pv_reg)
        begin
            prod_reg <= opa_reg * opb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `include "rpn_stack_calculator_unit_assert.svh"
    `RPN_ASSERT_IMPL(a_sp_bound, 1'b1, 32'(sp_reg) <= STACK_DEPTH, "stack pointer past depth")
    `RPN_ASSERT_NEXT(a_halt_sticky, halt_reg, halt_reg, "halt cleared")
    `RPN_ASSERT_IMPL(a_pop_idle, q_pop, state_reg == S_IDLE, "queue popped while busy")
endmodule
`default_nettype wire

// ===== sv/rpn_stack_calculator_unit.sv =====
// Clear/push/quit/unknown and halted beats are answered from the idle state;
// out first reads the stack RAM; add/sub and divide by zero read both operands;
// mul waits on the product; div/mod share the divider, one quotient bit a cycle.
// Throughput: one command at a time in the execute side; a two-entry queue
// decouples input acceptance. Stack RAM port limits reads to one per cycle.
// Reset: asynchronous, active low; clears stack pointer, halt flag and queue.
`default_nettype none
module rpn_stack_calculator_unit #(
    parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rpn_pkg::in_beat_t  in_beat,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output rpn_pkg::out_beat_t      out_beat,
    output logic                    out_valid,
    input  wire logic               out_stall
);
    rpn_pkg::cmd_t q_cmd;
    logic          q_valid;
    logic          q_pop;

    rpn_front u_front (
        .clk(clk), .rst_n(rst_n), .in_beat(in_beat), .in_valid(in_valid),
        .in_stall(in_stall), .q_cmd(q_cmd), .q_valid(q_valid), .q_pop(q_pop)
    );

    rpn_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_cmd(q_cmd), .q_valid(q_valid), .q_pop(q_pop),
        .out_beat(out_beat), .out_valid(out_valid), .out_stall(out_stall)
    );
endmodule
`default_nettype wire
